### rtl/core/ttcf_pkg.sv
// ----------------------------------------------------------------------------
// ttcf_pkg: shared types and constants for the timestamp to calendar core
// Beat payloads for the timestamp and calendar channels, the day-count
// constants of the civil-from-days breakdown and the month start table.
// ----------------------------------------------------------------------------
package ttcf_pkg;

  localparam int MicrosW = 58;
  localparam int ZoneW   = 5;

  // days from 0000-03-01 to 1970-01-01
  localparam logic [21:0] DayShift = 22'd719468;
  // 1970-01-01 was a Thursday
  localparam logic [21:0] WdayShift = 22'd4;

  typedef struct packed {
    logic [MicrosW-1:0] micros_since_epoch;
  } stamp_t;

  typedef struct packed {
    logic [13:0] year_number;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        leap_year;
    logic [9:0]  millisecond_part;
    logic [9:0]  microsecond_part;
  } cal_t;

  // first day of each month in a year that starts on March 1
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

### rtl/core/ttcf_if.sv
// ----------------------------------------------------------------------------
// ttcf_if: valid/ready channels of the timestamp to calendar core
// One interface for the timestamp beats and one for the calendar beats.
// ----------------------------------------------------------------------------
interface ttcf_stamp_if;
  logic             valid;
  logic             ready;
  ttcf_pkg::stamp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttcf_cal_if;
  logic           valid;
  logic           ready;
  ttcf_pkg::cal_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ttcf_cdiv.sv
// ----------------------------------------------------------------------------
// ttcf_cdiv: two-stage divider by a constant
// Exact quotient by reciprocal multiplication in the first stage, remainder
// by back-multiplication in the second. Each stage has its own enable.
// ----------------------------------------------------------------------------
module ttcf_cdiv #(
  parameter int W = 32,
  parameter int D = 675
) (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  logic [W-1:0]         x,
  output logic [W-1:0]         q,
  output logic [$clog2(D)-1:0] r
);

  localparam int L = $clog2(D);
  localparam int S = W + L;
  localparam logic [63:0] MFull = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [W:0] Recip = MFull[W:0];

  logic [2*W:0] prod;
  logic [W-1:0] q_s1;
  logic [W-1:0] x_s1;
  logic [W-1:0] qd;

  assign prod = (2*W+1)'(x) * (2*W+1)'(Recip);
  assign qd   = q_s1 * W'(D);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_s1 <= W'(prod >> S);
      x_s1 <= x;
    end
    if (en[1]) begin
      q <= q_s1;
      r <= L'(x_s1 - qd);
    end
  end

endmodule

### rtl/core/ttcf_delay.sv
// ----------------------------------------------------------------------------
// ttcf_delay: side-band register line
// Carries values alongside the pipeline, one register per stage, each
// stage loaded with that stage's enable.
// ----------------------------------------------------------------------------
module ttcf_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic [N-1:0] en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [N];

  always_ff @(posedge clk) begin
    if (en[0]) pipe[0] <= d;
    for (int i = 1; i < N; i++) begin
      if (en[i]) pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[N-1];

endmodule

### rtl/core/timestamp_to_calendar_fields_core.sv
// ----------------------------------------------------------------------------
// timestamp_to_calendar_fields_core: microsecond timestamp to calendar fields
// Applies a whole-hour zone offset and breaks the time into Gregorian
// year, month, day, time of day, weekday, day of year and sub-second parts.
// ----------------------------------------------------------------------------
// Usage:
//   stamp  : sink channel, one microsecond count since the epoch per beat.
//   fields : source channel, one calendar beat for each stamp beat, in order.
//   cfg_we / cfg_wdata : write the signed zone offset in hours; write only
//   while no beat is in flight.
// Pipeline: 25 register stages (three long divisions by 15625, day split,
//   civil-from-days chain, each constant division two stages).
// Throughput: one beat per cycle while the stages are not all full, set by the fully pipelined dividers.
// Stall: while fields.ready is low the stages hold their beats and empty
//   stages close up behind them; stamp.ready drops only once all 25 stages
//   hold a beat. Nothing is lost or repeated.
// Reset: clears every stage's valid bit and sets the zone offset to zero.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_fields_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic signed [ttcf_pkg::ZoneW-1:0] cfg_wdata,
  ttcf_stamp_if.sink                        stamp,
  ttcf_cal_if.source                        fields
);

  localparam int NS = 25;

  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  logic signed [ttcf_pkg::ZoneW-1:0] zone;
  logic signed [16:0]                zone_secs;

  logic [57:0] mic0;
  logic [19:0] qa;
  logic [13:0] ra;
  logic [37:0] lo2;
  logic [31:0] qb;
  logic [13:0] rb;
  logic [26:0] c4;
  logic [27:0] qc;
  logic [13:0] rc;
  logic [30:0] c6;

  logic signed [39:0] secs7;
  logic [19:0]        sub7;

  logic [19:0] qd;
  logic [9:0]  rd;
  logic [31:0] qe;
  logic [9:0]  re;
  logic [24:0] c9;

  logic [21:0] z10;
  logic [21:0] wx10;
  logic [16:0] sod10;

  logic [19:0] mu22;
  logic [21:0] qf;
  logic [17:0] rf;
  logic [2:0]  rg;
  logic [16:0] qh;
  logic [11:0] rh;
  logic [11:0] qi;
  logic [5:0]  ri;
  logic [17:0] qj1;
  logic [17:0] qj2;
  logic [17:0] qj3;
  logic [17:0] doe14;
  logic [17:0] doe19;
  logic [12:0] eh22;
  logic [11:0] mn22;

  logic [17:0] t15;
  logic [17:0] qk;
  logic [17:0] yd18;
  logic [17:0] yd19;
  logic [8:0]  ql;
  logic [8:0]  yoe22;
  logic [8:0]  doy_next;
  logic [8:0]  doy20;
  logic [10:0] x20;
  logic [10:0] qm;
  logic [8:0]  doy22;

  logic [3:0]     mp;
  logic           in_jan_feb;
  ttcf_pkg::cal_t res23;
  logic           march23;
  logic [8:0]     yp23;
  logic [8:0]     doy23;

  logic           cent;
  logic           quad_cent;
  logic           leap;
  logic [8:0]     yday;
  ttcf_pkg::cal_t out_next;
  ttcf_pkg::cal_t out_r;

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      adv[i] = fields.ready | ~(&(v | ((NS'(1) << i) - NS'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= stamp.valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  assign stamp.ready  = adv[0];
  assign fields.valid = v[NS-1];
  assign fields.data  = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg_we) begin
      zone <= cfg_wdata;
    end
  end

  assign zone_secs = zone * 17'sd3600;

  // --------------------------------------------------------------------------
  // Whole seconds: micros / 64 / 15625 in three digit steps
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[0]) mic0 <= stamp.data.micros_since_epoch;
  end

  ttcf_cdiv #(.W(20), .D(15625)) u_div_a (
    .clk(clk), .en(adv[2:1]), .x(mic0[57:38]), .q(qa), .r(ra)
  );

  ttcf_delay #(.W(38), .N(2)) u_dly_lo (
    .clk(clk), .en(adv[2:1]), .d(mic0[37:0]), .q(lo2)
  );

  ttcf_cdiv #(.W(32), .D(15625)) u_div_b (
    .clk(clk), .en(adv[4:3]), .x({ra, lo2[37:20]}), .q(qb), .r(rb)
  );

  ttcf_delay #(.W(27), .N(2)) u_dly_c4 (
    .clk(clk), .en(adv[4:3]), .d({qa[6:0], lo2[19:0]}), .q(c4)
  );

  ttcf_cdiv #(.W(28), .D(15625)) u_div_c (
    .clk(clk), .en(adv[6:5]), .x({rb, c4[19:6]}), .q(qc), .r(rc)
  );

  ttcf_delay #(.W(31), .N(2)) u_dly_c6 (
    .clk(clk), .en(adv[6:5]), .d({c4[26:20], qb[17:0], c4[5:0]}), .q(c6)
  );

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      secs7 <= $signed({1'b0, c6[30:6], qc[13:0]}) + 40'(zone_secs);
      sub7  <= {rc, c6[5:0]};
    end
  end

  // --------------------------------------------------------------------------
  // Sub-second parts and day split (secs / 128 / 675)
  // --------------------------------------------------------------------------
  ttcf_cdiv #(.W(20), .D(1000)) u_div_ms (
    .clk(clk), .en(adv[9:8]), .x(sub7), .q(qd), .r(rd)
  );

  ttcf_cdiv #(.W(32), .D(675)) u_div_day (
    .clk(clk), .en(adv[9:8]), .x(secs7[39] ? 32'd0 : secs7[38:7]), .q(qe), .r(re)
  );

  ttcf_delay #(.W(25), .N(2)) u_dly_c9 (
    .clk(clk), .en(adv[9:8]),
    .d({secs7[39], secs7[6:0], 17'(secs7 + 40'sd86400)}), .q(c9)
  );

  // before the epoch the shifted time always lands on the day before
  always_ff @(posedge clk) begin
    if (adv[10]) begin
      if (c9[24]) begin
        z10   <= ttcf_pkg::DayShift - 22'd1;
        wx10  <= ttcf_pkg::WdayShift - 22'd1;
        sod10 <= c9[16:0];
      end else begin
        z10   <= qe[21:0] + ttcf_pkg::DayShift;
        wx10  <= qe[21:0] + ttcf_pkg::WdayShift;
        sod10 <= {re[9:0], c9[23:17]};
      end
    end
  end

  ttcf_delay #(.W(20), .N(13)) u_dly_mu (
    .clk(clk), .en(adv[22:10]), .d({qd[9:0], rd}), .q(mu22)
  );

  // --------------------------------------------------------------------------
  // Era, weekday, time of day
  // --------------------------------------------------------------------------
  ttcf_cdiv #(.W(22), .D(146097)) u_div_era (
    .clk(clk), .en(adv[12:11]), .x(z10), .q(qf), .r(rf)
  );

  ttcf_cdiv #(.W(22), .D(7)) u_div_wday (
    .clk(clk), .en(adv[12:11]), .x(wx10), .q(), .r(rg)
  );

  ttcf_cdiv #(.W(17), .D(3600)) u_div_hour (
    .clk(clk), .en(adv[12:11]), .x(sod10), .q(qh), .r(rh)
  );

  ttcf_cdiv #(.W(12), .D(60)) u_div_min (
    .clk(clk), .en(adv[14:13]), .x(rh), .q(qi), .r(ri)
  );

  ttcf_cdiv #(.W(18), .D(1460)) u_div_j1 (
    .clk(clk), .en(adv[14:13]), .x(rf), .q(qj1), .r()
  );

  ttcf_cdiv #(.W(18), .D(36524)) u_div_j2 (
    .clk(clk), .en(adv[14:13]), .x(rf), .q(qj2), .r()
  );

  ttcf_cdiv #(.W(18), .D(146096)) u_div_j3 (
    .clk(clk), .en(adv[14:13]), .x(rf), .q(qj3), .r()
  );

  ttcf_delay #(.W(18), .N(2)) u_dly_doe_a (
    .clk(clk), .en(adv[14:13]), .d(rf), .q(doe14)
  );

  ttcf_delay #(.W(18), .N(5)) u_dly_doe_b (
    .clk(clk), .en(adv[19:15]), .d(doe14), .q(doe19)
  );

  ttcf_delay #(.W(13), .N(10)) u_dly_eh (
    .clk(clk), .en(adv[22:13]), .d({qf[4:0], rg, qh[4:0]}), .q(eh22)
  );

  ttcf_delay #(.W(12), .N(8)) u_dly_mn (
    .clk(clk), .en(adv[22:15]), .d({qi[5:0], ri}), .q(mn22)
  );

  // --------------------------------------------------------------------------
  // Year of era, day of year from March 1, month from March
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[15]) t15 <= doe14 - qj1 + qj2 - qj3;
  end

  ttcf_cdiv #(.W(18), .D(365)) u_div_yoe (
    .clk(clk), .en(adv[17:16]), .x(t15), .q(qk), .r()
  );

  always_ff @(posedge clk) begin
    if (adv[18]) yd18 <= 18'(qk[8:0]) * 18'd365 + 18'(qk[8:2]);
  end

  ttcf_cdiv #(.W(9), .D(100)) u_div_cent (
    .clk(clk), .en(adv[19:18]), .x(qk[8:0]), .q(ql), .r()
  );

  ttcf_delay #(.W(18), .N(1)) u_dly_yd (
    .clk(clk), .en(adv[19:19]), .d(yd18), .q(yd19)
  );

  ttcf_delay #(.W(9), .N(5)) u_dly_yoe (
    .clk(clk), .en(adv[22:18]), .d(qk[8:0]), .q(yoe22)
  );

  assign doy_next = 9'(doe19 - yd19 + 18'(ql[1:0]));

  always_ff @(posedge clk) begin
    if (adv[20]) begin
      doy20 <= doy_next;
      x20   <= 11'(doy_next) * 11'd5 + 11'd2;
    end
  end

  ttcf_cdiv #(.W(11), .D(153)) u_div_mp (
    .clk(clk), .en(adv[22:21]), .x(x20), .q(qm), .r()
  );

  ttcf_delay #(.W(9), .N(2)) u_dly_doy (
    .clk(clk), .en(adv[22:21]), .d(doy20), .q(doy22)
  );

  // --------------------------------------------------------------------------
  // Assemble calendar fields
  // --------------------------------------------------------------------------
  assign mp         = qm[3:0];
  assign in_jan_feb = (mp >= 4'd10);

  always_ff @(posedge clk) begin
    if (adv[23]) begin
      res23.year_number      <= 14'(eh22[12:8]) * 14'd400 + 14'(yoe22) + 14'(in_jan_feb);
      res23.month_index      <= in_jan_feb ? mp - 4'd10 : mp + 4'd2;
      res23.day_of_month     <= 5'(doy22 - ttcf_pkg::month_start(mp) + 9'd1);
      res23.hour_of_day      <= eh22[4:0];
      res23.minute_of_hour   <= mn22[11:6];
      res23.second_of_minute <= mn22[5:0];
      res23.weekday          <= eh22[7:5];
      res23.day_of_year      <= '0;
      res23.leap_year        <= 1'b0;
      res23.millisecond_part <= mu22[19:10];
      res23.microsecond_part <= mu22[9:0];
      march23                <= ~in_jan_feb;
      yp23                   <= yoe22 + 9'(in_jan_feb);
      doy23                  <= doy22;
    end
  end

  // year within its era decides the leap rule
  assign cent      = (yp23 == 9'd0) || (yp23 == 9'd100) || (yp23 == 9'd200) ||
                     (yp23 == 9'd300) || (yp23 == 9'd400);
  assign quad_cent = (yp23 == 9'd0) || (yp23 == 9'd400);
  assign leap      = ((yp23[1:0] == 2'd0) && !cent) || quad_cent;
  assign yday      = march23 ? doy23 + 9'd59 + 9'(leap) : doy23 - 9'd306;

  always_comb begin
    out_next             = res23;
    out_next.leap_year   = leap;
    out_next.day_of_year = yday;
  end

  always_ff @(posedge clk) begin
    if (adv[24]) out_r <= out_next;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !(&v) |-> stamp.ready)
    else $error("stamp not ready with an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (stamp.valid && stamp.ready) |=> v[0])
    else $error("accepted beat missing from first stage");

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    fields.valid |-> (fields.data.month_index < 4'd12) &&
                     (fields.data.day_of_month != 5'd0) &&
                     (fields.data.hour_of_day < 5'd24) &&
                     (fields.data.minute_of_hour < 6'd60) &&
                     (fields.data.second_of_minute < 6'd60) &&
                     (fields.data.weekday < 3'd7) &&
                     (fields.data.day_of_year < 9'd366))
    else $error("calendar field out of range");

  a_leap_year: assert property (@(posedge clk) disable iff (rst)
    (fields.valid && fields.data.leap_year) |-> (fields.data.year_number[1:0] == 2'd0))
    else $error("leap flag on a year not divisible by four");

endmodule

### verif/ttcf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcf_tb_pkg: calendar breakdown predictor and scoreboard
// Works out the expected calendar beat for each accepted timestamp under the
// current zone offset, queues it, and checks each calendar beat in order.
// ----------------------------------------------------------------------------
package ttcf_tb_pkg;
  import ttcf_pkg::*;

  localparam int MonthOffset [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  function automatic cal_t breakdown_stamp(input logic [57:0] micros,
                                           input logic signed [4:0] zone);
    longint us, secs, days, sod, wday, z, era, doe, yoe, yr, doy, mp, mday, mon, yday;
    bit     leap;
    cal_t   res;
    us   = longint'({6'd0, micros});
    secs = us / 1000000 + longint'(zone) * 3600;
    days = (secs >= 0) ? secs / 86400 : -((-secs + 86399) / 86400);
    sod  = secs - days * 86400;
    wday = ((days % 7) + 11) % 7;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr   = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mday = doy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) yr = yr + 1;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    yday = MonthOffset[mon - 1] + mday - 1 + ((leap && mon > 2) ? 1 : 0);
    res.year_number      = 14'(yr);
    res.month_index      = 4'(mon - 1);
    res.day_of_month     = 5'(mday);
    res.hour_of_day      = 5'(sod / 3600);
    res.minute_of_hour   = 6'((sod % 3600) / 60);
    res.second_of_minute = 6'(sod % 60);
    res.weekday          = 3'(wday);
    res.day_of_year      = 9'(yday);
    res.leap_year        = leap;
    res.millisecond_part = 10'((us % 1000000) / 1000);
    res.microsecond_part = 10'(us % 1000);
    return res;
  endfunction

  class calendar_scoreboard;
    cal_t              pending_fields[$];
    logic signed [4:0] zone_hours = '0;
    int unsigned       mismatches;
    int unsigned       fields_checked;

    function void note_stamp(input logic [57:0] micros);
      pending_fields.push_back(breakdown_stamp(micros, zone_hours));
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_fields(input cal_t got);
      cal_t want;
      if (pending_fields.size() == 0) begin
        $error("calendar beat arrived with no timestamp outstanding");
        mismatches++;
        return;
      end
      want = pending_fields.pop_front();
      fields_checked++;
      compare_field("year_number", want.year_number, got.year_number);
      compare_field("month_index", want.month_index, got.month_index);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
      compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
      compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
      compare_field("weekday", want.weekday, got.weekday);
      compare_field("day_of_year", want.day_of_year, got.day_of_year);
      compare_field("leap_year", want.leap_year, got.leap_year);
      compare_field("millisecond_part", want.millisecond_part, got.millisecond_part);
      compare_field("microsecond_part", want.microsecond_part, got.microsecond_part);
    endfunction
  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for timestamp_to_calendar_fields_core
// Sends directed and random microsecond timestamps under a range of zone
// offsets, with random gaps and stalls on both channels, and checks every
// calendar beat against a predicted breakdown in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import ttcf_pkg::*;
  import ttcf_tb_pkg::*;

  localparam logic signed [4:0] PhaseZones [8] = '{-5'sd16, 5'sd15, -5'sd12, 5'sd14,
                                                   5'sd0, -5'sd1, 5'sd5, -5'sd7};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic signed [4:0] cfg_wdata;
  bit                quiet;
  int unsigned       zone_writes;

  calendar_scoreboard sb = new;

  ttcf_stamp_if stamp_ch ();
  ttcf_cal_if   fields_ch ();

  timestamp_to_calendar_fields_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stamp     (stamp_ch),
    .fields    (fields_ch)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_cycles();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [57:0] stamp_at(input int y, input int mo, input int d,
                                           input int sec, input int sub);
    longint yy, era, yoe, doy, doe, days, total;
    yy    = (mo <= 2) ? y - 1 : y;
    era   = yy / 400;
    yoe   = yy - era * 400;
    doy   = (153 * ((mo > 2) ? mo - 3 : mo + 9) + 2) / 5 + d - 1;
    doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days  = era * 146097 + doe - 719468;
    total = (days * 86400 + sec) * 1000000 + sub;
    return total[57:0];
  endfunction

  function automatic logic [57:0] random_stamp();
    logic [63:0] wide;
    int          y;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    wide = {$urandom, $urandom};
    if (pick <= 2) return wide[57:0];
    if (pick <= 5) begin
      case ($urandom_range(0, 3))
        0: y = $urandom_range(1971, 11000);
        1: y = 100 * $urandom_range(20, 109);
        2: y = 400 * $urandom_range(5, 27);
        default: y = 4 * $urandom_range(493, 2750);
      endcase
      return stamp_at(y, $urandom_range(1, 12), $urandom_range(0, 1),
                      $urandom_range(0, 86399), $urandom_range(0, 999999));
    end
    if (pick <= 7)
      return stamp_at(1970, 1, 1, $urandom_range(0, 172800), $urandom_range(0, 999999));
    return 58'(longint'($urandom) * 1000000 + $urandom_range(0, 999999));
  endfunction

  task automatic send_stamp(input logic [57:0] micros);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      stamp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stamp_ch.valid <= 1'b1;
    stamp_ch.data.micros_since_epoch <= micros;
    do @(posedge clk); while (!stamp_ch.ready);
    sb.note_stamp(micros);
  endtask

  task automatic drain_results();
    stamp_ch.valid <= 1'b0;
    while (sb.pending_fields.size() != 0) @(posedge clk);
  endtask

  task automatic write_zone(input logic signed [4:0] hours);
    drain_results();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hours;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.zone_hours = hours;
    zone_writes++;
  endtask

  initial begin
    int unsigned stall;
    fields_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        fields_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      fields_ch.ready <= 1'b1;
      do @(posedge clk); while (!fields_ch.valid);
      sb.check_fields(fields_ch.data);
    end
  end

  initial begin
    logic [57:0] directed[$];
    stamp_ch.valid  <= 1'b0;
    stamp_ch.data   <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(58'd0);
    directed.push_back(58'd1);
    directed.push_back(58'd999);
    directed.push_back(58'd999999);
    directed.push_back(58'd1000000);
    directed.push_back(58'd86399999999);
    directed.push_back(58'd86400000000);
    directed.push_back(stamp_at(2000, 2, 29, 43200, 0));
    directed.push_back(stamp_at(2000, 3, 1, 0, 0));
    directed.push_back(stamp_at(2000, 12, 31, 86399, 999999));
    directed.push_back(stamp_at(1999, 12, 31, 86399, 999999));
    directed.push_back(stamp_at(2100, 2, 28, 86399, 999999));
    directed.push_back(stamp_at(2100, 3, 1, 0, 0));
    directed.push_back(stamp_at(2400, 2, 29, 3600, 500500));
    directed.push_back(58'(64'd2147483648 * 64'd1000000));
    directed.push_back(58'h2AAAAAAAAAAAAAA);
    directed.push_back(58'h155555555555555);
    directed.push_back('1);
    foreach (directed[i]) send_stamp(directed[i]);

    write_zone(-5'sd16);
    send_stamp(58'd0);
    send_stamp(58'd3599999999);
    send_stamp('1);
    write_zone(5'sd15);
    send_stamp('1);
    send_stamp(58'd0);

    for (int p = 0; p < 10; p++) begin
      write_zone((p < 8) ? PhaseZones[p] : 5'($urandom));
      quiet = (p % 3 == 1);
      repeat (65) send_stamp(random_stamp());
    end
    quiet = 1'b0;

    drain_results();
    repeat (30) @(posedge clk);
    $display("Checked %0d calendar beats over %0d zone offset writes (-16 to 15 hours).",
             sb.fields_checked, zone_writes);
    $display("Stimulus: epoch edges, month and year ends, leap centuries, full 58-bit range.");
    if (sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

### timestamp_to_calendar_fields_core.f
rtl/core/ttcf_pkg.sv
rtl/core/ttcf_if.sv
rtl/core/ttcf_cdiv.sv
rtl/core/ttcf_delay.sv
rtl/core/timestamp_to_calendar_fields_core.sv
verif/ttcf_tb_pkg.sv
verif/tb_top.sv
